// ----- sv/pli_pkg.sv -----
// Shared types, constants and codes of the piecewise-linear lookup interpolator.
package pli_pkg;

	// Table geometry
	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// Field widths
	localparam int FLOW_W  = 32;
	localparam int DUTY_W  = 16;
	localparam int PCNT_W  = 5;
	localparam int PIDX_W  = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	// Interpolation arithmetic: |dy * num| < 2^48
	localparam int PROD_W    = DUTY_W + 1 + FLOW_W + 1;
	localparam int DIV_W     = DUTY_W + FLOW_W;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_DUTY    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_DUTY = 2'd2;

	// Item actions
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef enum logic [2:0] {
		KIND_EMPTY    = 3'd0,
		KIND_LOW      = 3'd1,
		KIND_HIGH     = 3'd2,
		KIND_INTERP   = 3'd3,
		KIND_FALLBACK = 3'd4
	} kind_t;

	// Controller -> datapath
	typedef struct packed {
		logic  write_pt;
		logic  start;
		logic  ptr_last;
		logic  ptr_one;
		logic  ptr_next;
		logic  save_prev;
		logic  seg_load;
		logic  mul;
		logic  div_init;
		logic  div_step;
		logic  res_load;
		kind_t res_kind;
		logic  out_load;
	} dp_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic count_zero;
		logic le_first;
		logic ge_last;
		logic bracket;
		logic ptr_at_last;
		logic den_zero;
		logic div_last;
	} dp_status_t;

endpackage

// ----- sv/pli_datapath.sv -----
// Datapath: point table, config registers, segment search compares, multiply and serial divide.
module pli_datapath
	import pli_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	output dp_status_t           st,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_wdata,
	input  logic [PIDX_W-1:0]    point_index,
	input  logic [FLOW_W-1:0]    point_flow,
	input  logic [DUTY_W-1:0]    point_duty,
	input  logic [FLOW_W-1:0]    desired_flow,
	output logic [DUTY_W-1:0]    duty_out,
	output logic [2:0]           result_kind
);

	// Config registers
	logic [PCNT_W-1:0] point_count_q;
	logic [DUTY_W-1:0] empty_duty_q;
	logic [DUTY_W-1:0] fallback_duty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q   <= '0;
			empty_duty_q    <= '0;
			fallback_duty_q <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_POINT_COUNT:   point_count_q   <= cfg_wdata[PCNT_W-1:0];
				CFG_EMPTY_DUTY:    empty_duty_q    <= cfg_wdata;
				CFG_FALLBACK_DUTY: fallback_duty_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Point table, one write port and one registered read port
	logic [FLOW_W-1:0] flow_mem [TABLE_DEPTH];
	logic [DUTY_W-1:0] duty_mem [TABLE_DEPTH];
	logic [IDX_W-1:0]  ptr_q;
	logic [FLOW_W-1:0] rd_flow_q;
	logic [DUTY_W-1:0] rd_duty_q;
	logic              wr_ok;

	assign wr_ok = int'(point_index) < TABLE_DEPTH;

	always_ff @(posedge clk) begin
		if (cmd.write_pt && wr_ok) begin
			flow_mem[IDX_W'(point_index)] <= point_flow;
			duty_mem[IDX_W'(point_index)] <= point_duty;
		end
		rd_flow_q <= flow_mem[ptr_q];
		rd_duty_q <= duty_mem[ptr_q];
	end

	// Query context
	logic [FLOW_W-1:0] f_q;
	logic [IDX_W-1:0]  last_q;
	logic              zero_q;
	logic [FLOW_W-1:0] prev_flow_q;
	logic [DUTY_W-1:0] prev_duty_q;
	logic [CNT_W-1:0]  n_sat;

	always_comb begin
		if (int'(point_count_q) > TABLE_DEPTH)
			n_sat = CNT_W'(TABLE_DEPTH);
		else
			n_sat = CNT_W'(point_count_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			f_q    <= desired_flow;
			last_q <= IDX_W'(n_sat - CNT_W'(1));
			zero_q <= (n_sat == '0);
		end
		if (cmd.save_prev) begin
			prev_flow_q <= rd_flow_q;
			prev_duty_q <= rd_duty_q;
		end
		if (cmd.start)
			ptr_q <= '0;
		else if (cmd.ptr_last)
			ptr_q <= last_q;
		else if (cmd.ptr_one)
			ptr_q <= IDX_W'(1);
		else if (cmd.ptr_next)
			ptr_q <= ptr_q + IDX_W'(1);
	end

	// Segment operands
	logic [FLOW_W-1:0]        num_q;
	logic [FLOW_W-1:0]        den_q;
	logic signed [DUTY_W:0]   dy_q;
	logic [DUTY_W-1:0]        y0_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [PROD_W-1:0] prod_w;
	logic signed [PROD_W-1:0] mag_w;

	assign prod_w = dy_q * $signed({1'b0, num_q});
	assign mag_w  = prod_s1[PROD_W-1] ? -prod_s1 : prod_s1;

	always_ff @(posedge clk) begin
		if (cmd.seg_load) begin
			num_q <= f_q - prev_flow_q;
			den_q <= rd_flow_q - prev_flow_q;
			dy_q  <= $signed({1'b0, rd_duty_q}) - $signed({1'b0, prev_duty_q});
			y0_q  <= prev_duty_q;
		end
		if (cmd.mul)
			prod_s1 <= prod_w;
	end

	// Restoring divider, one quotient bit per cycle
	logic [FLOW_W-1:0]    rem_q;
	logic [DIV_W-1:0]     dq_q;
	logic                 neg_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [FLOW_W:0]      rem_sh;
	logic [FLOW_W:0]      den_ext;
	logic                 q_bit;
	logic [FLOW_W-1:0]    rem_nx;

	always_comb begin
		rem_sh  = {rem_q, dq_q[DIV_W-1]};
		den_ext = {1'b0, den_q};
		q_bit   = (rem_sh >= den_ext);
		rem_nx  = q_bit ? FLOW_W'(rem_sh - den_ext) : rem_sh[FLOW_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q     <= '0;
			dq_q      <= mag_w[DIV_W-1:0];
			neg_q     <= prod_s1[PROD_W-1];
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q     <= rem_nx;
			dq_q      <= {dq_q[DIV_W-2:0], q_bit};
			div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
		end
	end

	// Quotient magnitude never exceeds |dy|, so 16 bits carry it
	logic [DUTY_W+1:0] q_ext;
	logic [DUTY_W+1:0] q_sgn;
	logic [DUTY_W+1:0] sum_w;
	logic [DUTY_W-1:0] interp_duty;

	always_comb begin
		q_ext       = {2'b00, dq_q[DUTY_W-1:0]};
		q_sgn       = neg_q ? ((DUTY_W+2)'(0) - q_ext) : q_ext;
		sum_w       = {2'b00, y0_q} + q_sgn;
		interp_duty = (den_q == '0) ? y0_q : sum_w[DUTY_W-1:0];
	end

	// Result holding register and output register
	logic [DUTY_W-1:0] res_duty_q;
	kind_t             res_kind_q;
	logic [DUTY_W-1:0] out_duty_q;
	kind_t             out_kind_q;
	logic [DUTY_W-1:0] res_duty_w;

	always_comb begin
		unique case (cmd.res_kind)
			KIND_EMPTY:    res_duty_w = empty_duty_q;
			KIND_LOW:      res_duty_w = rd_duty_q;
			KIND_HIGH:     res_duty_w = rd_duty_q;
			KIND_INTERP:   res_duty_w = interp_duty;
			KIND_FALLBACK: res_duty_w = fallback_duty_q;
			default:       res_duty_w = fallback_duty_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_duty_q <= res_duty_w;
			res_kind_q <= cmd.res_kind;
		end
		if (cmd.out_load) begin
			out_duty_q <= res_duty_q;
			out_kind_q <= res_kind_q;
		end
	end

	assign duty_out    = out_duty_q;
	assign result_kind = out_kind_q;

	// Status
	assign st.count_zero  = zero_q;
	assign st.le_first    = (f_q <= rd_flow_q);
	assign st.ge_last     = (f_q >= rd_flow_q);
	assign st.bracket     = (f_q >= prev_flow_q) && (f_q <= rd_flow_q);
	assign st.ptr_at_last = (ptr_q == last_q);
	assign st.den_zero    = (den_q == '0);
	assign st.div_last    = (div_cnt_q == DIV_CNT_W'(DIV_W - 1));

endmodule

// ----- sv/pli_ctrl.sv -----
// Controller state machine: input/output handshakes and sequencing of the search and divide.
module pli_ctrl
	import pli_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       action,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t st,
	output dp_cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD0,
		S_CHK0,
		S_CHKL,
		S_SRD,
		S_SCHK,
		S_MUL,
		S_DINIT,
		S_DIV,
		S_FIN,
		S_EMIT
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   out_valid_q;
	logic   in_acc;
	logic   slot_free;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd      = '0;
		cmd.res_kind = KIND_EMPTY;
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (action == ACT_WRITE) begin
						cmd.write_pt = 1'b1;
					end else begin
						cmd.start = 1'b1;
						state_nx  = S_RD0;
					end
				end
			end
			S_RD0: begin
				if (st.count_zero) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = KIND_EMPTY;
					state_nx     = S_EMIT;
				end else begin
					cmd.ptr_last = 1'b1;
					state_nx     = S_CHK0;
				end
			end
			S_CHK0: begin
				if (st.le_first) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = KIND_LOW;
					state_nx     = S_EMIT;
				end else begin
					cmd.save_prev = 1'b1;
					state_nx      = S_CHKL;
				end
			end
			S_CHKL: begin
				if (st.ge_last) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = KIND_HIGH;
					state_nx     = S_EMIT;
				end else begin
					cmd.ptr_one = 1'b1;
					state_nx    = S_SRD;
				end
			end
			S_SRD: state_nx = S_SCHK;
			S_SCHK: begin
				if (st.bracket) begin
					cmd.seg_load = 1'b1;
					state_nx     = S_MUL;
				end else if (st.ptr_at_last) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = KIND_FALLBACK;
					state_nx     = S_EMIT;
				end else begin
					cmd.save_prev = 1'b1;
					cmd.ptr_next  = 1'b1;
					state_nx      = S_SRD;
				end
			end
			S_MUL: begin
				if (st.den_zero) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = KIND_INTERP;
					state_nx     = S_EMIT;
				end else begin
					cmd.mul  = 1'b1;
					state_nx = S_DINIT;
				end
			end
			S_DINIT: begin
				cmd.div_init = 1'b1;
				state_nx     = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last)
					state_nx = S_FIN;
			end
			S_FIN: begin
				cmd.res_load = 1'b1;
				cmd.res_kind = KIND_INTERP;
				state_nx     = S_EMIT;
			end
			S_EMIT: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- sv/piecewise_linear_lut_interpolator.sv -----
// Top level of the piecewise-linear lookup table interpolator.
// Input channel (in_valid/in_ready): one beat carries action, point_index,
//   point_flow, point_duty and desired_flow. A write beat stores one table
//   point (index at or above the table depth is dropped) and gives no result.
//   A query beat gives exactly one output beat (duty_out, result_kind).
// Config port: cfg_we/cfg_index/cfg_wdata, index 0 point_count, 1 empty_duty,
//   2 fallback_duty; write it only while the block is idle.
// Sequence: a write stores its point from the idle state. A query first
//   checks for an empty table, reads entry 0 for the clamped-low check, then
//   the last entry for the clamped-high check, then scans one segment at a
//   time through the single registered read port (fallback after the last
//   segment). Equal flows on a segment skip the divide; interpolation runs a
//   multiply, then a restoring divider, one quotient bit per cycle over 48
//   bits. One query is in flight at a time.
// Output: the result sits in an output register; in_ready returns as soon as
//   it is loaded, so a new beat is taken while the receiver stalls. A second
//   result waits in the result register until the output register frees up.
// Reset (arst_n low): controller idle, no output valid, point_count 0,
//   empty_duty 0, fallback_duty 65535. Table contents stay undefined until
//   written.
module piecewise_linear_lut_interpolator
	import pli_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_wdata,
	// input beats
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 action,
	input  logic [PIDX_W-1:0]    point_index,
	input  logic [FLOW_W-1:0]    point_flow,
	input  logic [DUTY_W-1:0]    point_duty,
	input  logic [FLOW_W-1:0]    desired_flow,
	// result beats
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [DUTY_W-1:0]    duty_out,
	output logic [2:0]           result_kind
);

	dp_cmd_t    cmd;
	dp_status_t st;

	// Sequencer: handshakes, clamp checks, segment scan, divide stepping
	pli_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	// Table, config registers, compares, multiplier and divider
	pli_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.point_index  (point_index),
		.point_flow   (point_flow),
		.point_duty   (point_duty),
		.desired_flow (desired_flow),
		.duty_out     (duty_out),
		.result_kind  (result_kind)
	);

endmodule

// ----- tb/pli_duty_checker.sv -----
// Checker for the interpolator: follows table, register and query beats, predicts duties, compares.
`timescale 1ns / 1ps
module pli_duty_checker
	import pli_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_wdata,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic                 action,
	input  logic [PIDX_W-1:0]    point_index,
	input  logic [FLOW_W-1:0]    point_flow,
	input  logic [DUTY_W-1:0]    point_duty,
	input  logic [FLOW_W-1:0]    desired_flow,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [DUTY_W-1:0]    duty_out,
	input  logic [2:0]           result_kind,
	output int                   mismatch_count,
	output int                   duties_pending
);

	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		kind_t             kind;
	} duty_beat_t;

	logic [FLOW_W-1:0] flow_tab [TABLE_DEPTH];
	logic [DUTY_W-1:0] duty_tab [TABLE_DEPTH];
	logic [PCNT_W-1:0] pts_in_use;
	logic [DUTY_W-1:0] empty_val;
	logic [DUTY_W-1:0] fallback_val;
	duty_beat_t        duty_expected_q [$];
	duty_beat_t        want;
	int                errs = 0;

	assign mismatch_count = errs;

	task automatic report_mismatch(input string msg);
		if (errs < 100)
			$display("MISMATCH @%0t: %s", $time, msg);
		errs++;
	endtask

	function automatic duty_beat_t predict_duty(input logic [FLOW_W-1:0] f);
		duty_beat_t        r;
		int                n;
		int                i;
		longint            dy;
		longint            num;
		longint            den;
		longint            q;
		logic [FLOW_W-1:0] x0;
		logic [FLOW_W-1:0] x1;
		n = (pts_in_use > TABLE_DEPTH) ? TABLE_DEPTH : int'(pts_in_use);
		if (n == 0) begin
			r.duty = empty_val;
			r.kind = KIND_EMPTY;
			return r;
		end
		if (f <= flow_tab[0]) begin
			r.duty = duty_tab[0];
			r.kind = KIND_LOW;
			return r;
		end
		if (f >= flow_tab[n-1]) begin
			r.duty = duty_tab[n-1];
			r.kind = KIND_HIGH;
			return r;
		end
		for (i = 0; i + 1 < n; i++) begin
			x0 = flow_tab[i];
			x1 = flow_tab[i+1];
			if (f >= x0 && f <= x1) begin
				r.kind = KIND_INTERP;
				if (x0 == x1) begin
					r.duty = duty_tab[i];
				end else begin
					// signed slope, wide product, quotient truncated toward zero
					dy = longint'(duty_tab[i+1]) - longint'(duty_tab[i]);
					num = {32'd0, f - x0};
					den = {32'd0, x1 - x0};
					q = (dy * num) / den;
					r.duty = DUTY_W'(longint'(duty_tab[i]) + q);
				end
				return r;
			end
		end
		r.duty = fallback_val;
		r.kind = KIND_FALLBACK;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pts_in_use = '0;
			empty_val = '0;
			fallback_val = '1;
			duty_expected_q.delete();
			duties_pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_POINT_COUNT:   pts_in_use = PCNT_W'(cfg_wdata);
					CFG_EMPTY_DUTY:    empty_val = cfg_wdata;
					CFG_FALLBACK_DUTY: fallback_val = cfg_wdata;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (action == ACT_WRITE) begin
					if (point_index < TABLE_DEPTH) begin
						flow_tab[point_index] = point_flow;
						duty_tab[point_index] = point_duty;
					end
				end else begin
					duty_expected_q.push_back(predict_duty(desired_flow));
				end
			end
			if (out_valid && out_ready) begin
				if (duty_expected_q.size() == 0) begin
					report_mismatch($sformatf("result beat with no query outstanding: duty %0d kind %0d",
						duty_out, result_kind));
				end else begin
					want = duty_expected_q.pop_front();
					if (duty_out !== want.duty)
						report_mismatch($sformatf("duty_out %0d, expected %0d",
							duty_out, want.duty));
					if (result_kind !== want.kind)
						report_mismatch($sformatf("result_kind %0d, expected %0d",
							result_kind, want.kind));
				end
			end
			duties_pending <= duty_expected_q.size();
		end
	end

endmodule

// ----- tb/piecewise_linear_lut_interpolator_test.sv -----
// Top of the interpolator testbench: clock, reset, beat stimulus, stalls and verdict.
`timescale 1ns / 1ps
module piecewise_linear_lut_interpolator_test
	import pli_pkg::*;
;

	// index 3 decodes to no register; a write there must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	// no random phase starts once this many beats have been taken (directed ones included)
	localparam int BEAT_TARGET = 770;
	// from here on neither side idles
	localparam int QUIET_FROM  = 650;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_wdata = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 action = ACT_WRITE;
	logic [PIDX_W-1:0]    point_index = '0;
	logic [FLOW_W-1:0]    point_flow = '0;
	logic [DUTY_W-1:0]    point_duty = '0;
	logic [FLOW_W-1:0]    desired_flow = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [DUTY_W-1:0]    duty_out;
	logic [2:0]           result_kind;

	int mismatch_count;
	int duties_pending;

	// Stimulus-side copy of the table flows, only used to aim queries at
	// interesting spots; prediction lives in the checker.
	logic [FLOW_W-1:0] shadow_flow [TABLE_DEPTH] = '{default: '0};
	int                table_len = 0;
	int                beats_sent = 0;
	bit                quiet = 1'b0;
	bit                hold_req = 1'b0;

	piecewise_linear_lut_interpolator DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.point_index  (point_index),
		.point_flow   (point_flow),
		.point_duty   (point_duty),
		.desired_flow (desired_flow),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.duty_out     (duty_out),
		.result_kind  (result_kind)
	);

	pli_duty_checker duty_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.point_index    (point_index),
		.point_flow     (point_flow),
		.point_duty     (point_duty),
		.desired_flow   (desired_flow),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.duty_out       (duty_out),
		.result_kind    (result_kind),
		.mismatch_count (mismatch_count),
		.duties_pending (duties_pending)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Run limit: far beyond the slowest legal run (every query interpolating
	// at 16 points, every beat behind a full stall).
	initial begin
		#20_000_000;
		$display("FAIL piecewise_linear_lut_interpolator");
		$finish;
	end

	// Result side. Random ready drops, none once quiet is set.
	// hold_req asks for one long hold-off so the block backs up into its
	// input; the hold is counted here so the sender keeps offering beats.
	initial begin
		int b;
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				b = $urandom_range(1, 4);
				out_ready <= 1'b0;
				repeat (b) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	function automatic logic [DUTY_W-1:0] pick_duty();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return DUTY_W'($urandom());
		endcase
	endfunction

	// Query flows: the range ends, random flows, exact table flows and their
	// neighbors, and most often points inside some segment of the current table.
	function automatic logic [FLOW_W-1:0] pick_flow();
		int                j;
		logic [FLOW_W-1:0] lo;
		logic [FLOW_W-1:0] hi;
		logic [FLOW_W-1:0] t;
		j = (table_len > 1) ? $urandom_range(0, table_len - 2) : 0;
		lo = shadow_flow[j];
		hi = shadow_flow[j+1];
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return $urandom();
			3: return shadow_flow[j];
			4: begin
				if ($urandom_range(0, 1))
					return shadow_flow[j] + 32'd1;
				return shadow_flow[j] - 32'd1;
			end
			default: begin
				if (lo > hi) begin
					t = lo;
					lo = hi;
					hi = t;
				end
				return lo + FLOW_W'({$urandom(), $urandom()} % ({32'd0, hi - lo} + 64'd1));
			end
		endcase
	endfunction

	// One input beat. Optional idle gap first, then valid held with a stable
	// payload until the handshake; in_ready is read as it stood at the edge.
	task automatic send_beat(input logic act, input logic [PIDX_W-1:0] idx,
			input logic [FLOW_W-1:0] pf, input logic [DUTY_W-1:0] pd,
			input logic [FLOW_W-1:0] df);
		int gap;
		gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		point_index <= idx;
		point_flow <= pf;
		point_duty <= pd;
		desired_flow <= df;
		do @(posedge clk); while (!in_ready);
		beats_sent++;
	endtask

	// Unused payload fields get random values so the block must ignore them.
	task automatic write_point(input logic [PIDX_W-1:0] idx, input logic [FLOW_W-1:0] f,
			input logic [DUTY_W-1:0] d);
		shadow_flow[idx] = f;
		send_beat(ACT_WRITE, idx, f, d, $urandom());
	endtask

	task automatic query_duty(input logic [FLOW_W-1:0] f);
		send_beat(ACT_QUERY, PIDX_W'($urandom()), $urandom(), pick_duty(), f);
	endtask

	// Stop offering beats and wait until every query has been answered, then
	// let a trailing point write land.
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (duties_pending != 0);
		repeat (8) @(posedge clk);
	endtask

	// Back-to-back register writes; only called with the block idle.
	task automatic set_config(input logic [PCNT_W-1:0] n, input logic [DUTY_W-1:0] e,
			input logic [DUTY_W-1:0] fb, input bit poke_spare);
		cfg_we <= 1'b1;
		cfg_index <= CFG_POINT_COUNT;
		cfg_wdata <= CFG_DAT_W'(n);
		@(posedge clk);
		cfg_index <= CFG_EMPTY_DUTY;
		cfg_wdata <= e;
		@(posedge clk);
		cfg_index <= CFG_FALLBACK_DUTY;
		cfg_wdata <= fb;
		@(posedge clk);
		if (poke_spare) begin
			cfg_index <= CFG_SPARE;
			cfg_wdata <= CFG_DAT_W'($urandom());
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// Fresh table in entries 0..k-1. Mostly rising flows (narrow steps from a
	// random start, or wide steps across the range), some with repeated flows,
	// and some unordered tables.
	task automatic load_table(input int k);
		int                mode;
		int                i;
		longint unsigned   acc;
		mode = $urandom_range(0, 9);
		acc = (mode < 3) ? longint'($urandom()) : longint'($urandom_range(0, 255));
		for (i = 0; i < k; i++) begin
			if (mode >= 8)
				acc = $urandom();
			else if (i > 0 && mode < 3)
				acc += $urandom_range(1, 64);
			else if (i > 0 && mode < 6)
				acc += $urandom_range(1, 32'h0FFF_FFFF);
			else if (i > 0)
				acc += $urandom_range(0, 3);
			if (acc > 64'hFFFF_FFFF)
				acc = 64'hFFFF_FFFF;
			write_point(PIDX_W'(i), acc[FLOW_W-1:0], pick_duty());
		end
		table_len = k;
	endtask

	initial begin
		int p;
		int n;
		int burst;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		// Reset leaves no points in use: both flow extremes give the empty duty.
		query_duty('0);
		query_duty('1);

		// Four points: rising first segment, a repeated flow, a falling last
		// segment up near the top of the range. Entry 15 is written too.
		write_point(4'd0, 32'h0000_0010, 16'h0000);
		write_point(4'd1, 32'h0000_1000, 16'hFFFF);
		write_point(4'd2, 32'h0000_1000, 16'h1234);
		write_point(4'd3, 32'hFFFF_FFF0, 16'h0001);
		write_point(4'd15, '1, '1);
		table_len = 4;
		wait_idle();
		set_config(5'd4, 16'hFFFF, 16'h0000, 1'b0);

		query_duty(32'h0000_0000);   // below the first flow
		query_duty(32'h0000_0010);   // on the first flow: still clamped low
		query_duty(32'h0000_0011);   // first step inside the rising segment
		query_duty(32'h0000_0800);
		query_duty(32'h0000_1000);   // on the repeated flow: left segment wins
		query_duty(32'h0000_1001);   // falling slope, quotient rounds toward zero
		query_duty(32'h8000_0000);
		query_duty(32'hFFFF_FFF0);   // on the last flow: clamped high
		query_duty(32'hFFFF_FFFF);

		// --- random part ---
		// Each phase: go idle, program the registers, load a table covering
		// every entry in use, then a burst of queries mixed with rewrites.
		// The first phases pin the count extremes: beyond depth, full, one
		// point, none. Phase 5 carries the long receiver hold-off.
		p = 0;
		while (beats_sent < BEAT_TARGET) begin
			wait_idle();
			quiet = (beats_sent >= QUIET_FROM);
			case (p)
				0: n = 31;
				1: n = TABLE_DEPTH;
				2: n = 1;
				3: n = 0;
				default: begin
					case ($urandom_range(0, 9))
						0:       n = $urandom_range(TABLE_DEPTH + 1, 31);
						1:       n = $urandom_range(0, 1);
						default: n = $urandom_range(2, TABLE_DEPTH);
					endcase
				end
			endcase
			set_config(PCNT_W'(n), pick_duty(), pick_duty(), p == 1);
			load_table((n > TABLE_DEPTH) ? TABLE_DEPTH : n);
			if (p == 5)
				hold_req = 1'b1;
			burst = (p == 5) ? 40 : $urandom_range(8, 30);
			repeat (burst) begin
				// rewrites may break the ordering; any table entry is fair game
				if ($urandom_range(0, 6) == 0)
					write_point(PIDX_W'($urandom()), $urandom(), pick_duty());
				else
					query_duty(pick_flow());
			end
			p++;
		end

		wait_idle();
		repeat (100) @(posedge clk);
		if (mismatch_count == 0 && duties_pending == 0)
			$display("PASS piecewise_linear_lut_interpolator");
		else
			$display("FAIL piecewise_linear_lut_interpolator");
		$finish;
	end

endmodule

// ----- files.f -----
sv/pli_pkg.sv
sv/pli_datapath.sv
sv/pli_ctrl.sv
sv/piecewise_linear_lut_interpolator.sv
tb/pli_duty_checker.sv
tb/piecewise_linear_lut_interpolator_test.sv
